// File: rtl/dtp_pkg.sv
// Types, constants and helpers shared by the deadline timer pool modules.
`default_nettype none

package dtp_pkg;

	localparam int SLOTS      = 64;
	localparam int OWNER_BITS = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	typedef enum logic [2:0] {
		MODE_ARM    = 3'd0,
		MODE_CANCEL = 3'd1,
		MODE_TICK   = 3'd2,
		MODE_HALT   = 3'd3,
		MODE_RUN    = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ARMED = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_FIRED = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] owner_id;
		logic [31:0] delay_ms;
		logic [31:0] now_ms;
	} cmd_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  slot;
		logic [15:0] fired_owner;
		logic [6:0]  cancelled_count;
		logic        last;
	} res_item_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                  start;
		logic                  start_up;
		logic                  adv;
		logic                  kill;
		logic                  dir_up;
		mode_t                 op;
		logic [OWNER_BITS-1:0] owner;
		logic [31:0]           key;
	} cell_ctl_t;

	typedef struct packed {
		logic                  hit;
		logic [OWNER_BITS-1:0] owner;
	} cell_rsp_t;

	function automatic logic [OWNER_BITS-1:0] owner_of(input logic [15:0] id);
		logic [31:0] w;
		w = 32'(id);
		return w[OWNER_BITS-1:0];
	endfunction

	function automatic res_item_t res_make(input kind_t k, input logic [SLOT_W-1:0] s,
			input logic [OWNER_BITS-1:0] o, input logic [CNT_W-1:0] c, input logic l);
		res_item_t r;
		logic [31:0] ws;
		logic [31:0] wo;
		logic [31:0] wc;
		ws = 32'(s);
		wo = 32'(o);
		wc = 32'(c);
		r.kind            = k;
		r.slot            = ws[5:0];
		r.fired_owner     = wo[15:0];
		r.cancelled_count = wc[6:0];
		r.last            = l;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/dtp_cell.sv
// One timer slot of the chain: valid bit, owner, deadline and the scan token.
`default_nettype none

module dtp_cell import dtp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      seed,
	input  wire logic      tok_lo,
	input  wire logic      tok_hi,
	output logic           tok,
	output cell_rsp_t      rsp
);

	logic                  tok_q;
	logic                  valid_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [31:0]           deadline_q;
	logic                  match;
	logic                  act;

	always_comb begin
		case (ctl.op)
			MODE_ARM:    match = !valid_q;
			MODE_CANCEL: match = valid_q && (owner_q == ctl.owner);
			MODE_CLEAR:  match = valid_q;
			MODE_TICK:   match = valid_q && (deadline_q <= ctl.key);
			default:     match = 1'b0;
		endcase
	end

	assign act = tok_q && ctl.adv && match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.kill) begin
				tok_q <= 1'b0;
			end else if (ctl.start) begin
				tok_q <= seed;
			end else if (ctl.adv) begin
				tok_q <= ctl.dir_up ? tok_lo : tok_hi;
			end
			if (act) begin
				valid_q <= (ctl.op == MODE_ARM);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act && ctl.op == MODE_ARM) begin
			owner_q    <= ctl.owner;
			deadline_q <= ctl.key;
		end
	end

	assign tok       = tok_q;
	assign rsp.hit   = tok_q && match;
	assign rsp.owner = (tok_q && match) ? owner_q : '0;

endmodule

`default_nettype wire

// File: rtl/dtp_ctrl.sv
// Command sequencer: starts scans, gathers cell hits and builds result items.
`default_nettype none

module dtp_ctrl import dtp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	input  wire cmd_item_t             cmd,
	output logic                       cmd_stall,
	output logic                       res_valid,
	output res_item_t                  res,
	input  wire logic                  res_stall,
	input  wire logic                  hit,
	input  wire logic [OWNER_BITS-1:0] hit_owner,
	output cell_ctl_t                  ctl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                state_q, state_d;
	logic                  halted_q, halted_d;
	mode_t                 op_q, op_d;
	logic [OWNER_BITS-1:0] owner_q, owner_d;
	logic [31:0]           key_q, key_d;
	logic [SLOT_W-1:0]     idx_q, idx_d;
	logic                  dir_up_q, dir_up_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  pend_vld_q, pend_vld_d;
	logic [SLOT_W-1:0]     pend_slot_q, pend_slot_d;
	logic [OWNER_BITS-1:0] pend_owner_q, pend_owner_d;
	res_item_t             fin_q, fin_d;
	logic                  out_vld_q;
	res_item_t             out_q, out_d;
	logic                  out_ld;
	logic                  out_busy;
	logic                  adv;
	logic                  start;
	logic                  start_up;
	logic                  kill;
	logic                  at_end;

	assign out_busy = out_vld_q && res_stall;
	assign at_end   = idx_q == (dir_up_q ? SLOT_LAST : '0);

	always_comb begin
		state_d      = state_q;
		halted_d     = halted_q;
		op_d         = op_q;
		owner_d      = owner_q;
		key_d        = key_q;
		idx_d        = idx_q;
		dir_up_d     = dir_up_q;
		cnt_d        = cnt_q;
		pend_vld_d   = pend_vld_q;
		pend_slot_d  = pend_slot_q;
		pend_owner_d = pend_owner_q;
		fin_d        = fin_q;
		out_ld       = 1'b0;
		out_d        = out_q;
		adv          = 1'b0;
		start        = 1'b0;
		start_up     = 1'b0;
		kill         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					owner_d    = owner_of(cmd.owner_id);
					cnt_d      = '0;
					pend_vld_d = 1'b0;
					fin_d      = res_make(KIND_DONE, '0, '0, '0, 1'b1);
					state_d    = ST_FIN;
					case (cmd.mode)
						MODE_ARM: begin
							start    = 1'b1;
							start_up = 1'b1;
							op_d     = MODE_ARM;
							key_d    = cmd.now_ms + cmd.delay_ms;
							idx_d    = '0;
							dir_up_d = 1'b1;
							state_d  = ST_SCAN;
						end
						MODE_CANCEL, MODE_CLEAR: begin
							start    = 1'b1;
							op_d     = mode_t'(cmd.mode);
							idx_d    = SLOT_LAST;
							dir_up_d = 1'b0;
							state_d  = ST_SCAN;
						end
						MODE_TICK, MODE_RUN: begin
							if (cmd.mode == MODE_RUN) begin
								halted_d = 1'b0;
							end
							if (!halted_q || cmd.mode == MODE_RUN) begin
								start    = 1'b1;
								op_d     = MODE_TICK;
								key_d    = cmd.now_ms;
								idx_d    = SLOT_LAST;
								dir_up_d = 1'b0;
								state_d  = ST_SCAN;
							end
						end
						MODE_HALT: begin
							halted_d = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				adv = !(op_q == MODE_TICK && hit && pend_vld_q && out_busy);
				if (adv) begin
					idx_d = dir_up_q ? idx_q + 1'b1 : idx_q - 1'b1;
					if (hit) begin
						case (op_q)
							MODE_ARM: begin
								kill    = 1'b1;
								fin_d   = res_make(KIND_ARMED, idx_q, owner_q, '0, 1'b1);
								state_d = ST_FIN;
							end
							MODE_TICK: begin
								if (pend_vld_q) begin
									out_ld = 1'b1;
									out_d  = res_make(KIND_FIRED, pend_slot_q, pend_owner_q,
										'0, 1'b0);
								end
								pend_vld_d   = 1'b1;
								pend_slot_d  = idx_q;
								pend_owner_d = hit_owner;
							end
							default: cnt_d = cnt_q + 1'b1;
						endcase
					end
					if (at_end && !(hit && op_q == MODE_ARM)) begin
						pend_vld_d = 1'b0;
						state_d    = ST_FIN;
						case (op_q)
							MODE_ARM: fin_d = res_make(KIND_FULL, '0, '0, '0, 1'b1);
							MODE_TICK: begin
								if (hit) begin
									fin_d = res_make(KIND_FIRED, idx_q, hit_owner, '0, 1'b1);
								end else if (pend_vld_q) begin
									fin_d = res_make(KIND_FIRED, pend_slot_q, pend_owner_q,
										'0, 1'b1);
								end else begin
									fin_d = res_make(KIND_DONE, '0, '0, '0, 1'b1);
								end
							end
							default: fin_d = res_make(KIND_DONE, '0, '0,
								cnt_q + CNT_W'(hit), 1'b1);
						endcase
					end
				end
			end
			ST_FIN: begin
				if (!out_busy) begin
					out_ld  = 1'b1;
					out_d   = fin_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			halted_q   <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			halted_q   <= halted_d;
			pend_vld_q <= pend_vld_d;
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (!res_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		owner_q      <= owner_d;
		key_q        <= key_d;
		idx_q        <= idx_d;
		dir_up_q     <= dir_up_d;
		cnt_q        <= cnt_d;
		pend_slot_q  <= pend_slot_d;
		pend_owner_q <= pend_owner_d;
		fin_q        <= fin_d;
		out_q        <= out_d;
	end

	assign cmd_stall    = state_q != ST_IDLE;
	assign res_valid    = out_vld_q;
	assign res          = out_q;
	assign ctl.start    = start;
	assign ctl.start_up = start_up;
	assign ctl.adv      = adv;
	assign ctl.kill     = kill;
	assign ctl.dir_up   = dir_up_q;
	assign ctl.op       = op_q;
	assign ctl.owner    = owner_q;
	assign ctl.key      = key_q;

endmodule

`default_nettype wire

// File: rtl/deadline_timer_pool.sv
// Top level: a pool of one-shot deadline timers held in a chain of slot cells.
// Arm takes the lowest free slot; cancel, clear, tick and run scan every slot; halt,
// unused modes and a halted tick scan none. Results leave via an output register.
// Throughput: one item at a time; a scan token visits one cell per cycle, but in a
// tick it waits while a new hit must pass on a pending fired item and output stalls.
// Reset clears all valid bits, the halt flag and the scan state at once.
`default_nettype none

module deadline_timer_pool import dtp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire cmd_item_t cmd,
	output logic           cmd_stall,
	output logic           res_valid,
	output res_item_t      res,
	input  wire logic      res_stall
);

	cell_ctl_t             ctl;
	cell_rsp_t             rsp [SLOTS];
	logic [SLOTS-1:0]      tok_vec;
	logic [SLOTS-1:0]      seed;
	logic [SLOTS-1:0]      tok_lo;
	logic [SLOTS-1:0]      tok_hi;
	logic                  hit;
	logic [OWNER_BITS-1:0] hit_owner;

	dtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall),
		.hit       (hit),
		.hit_owner (hit_owner),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_lo_end
			assign tok_lo[i] = 1'b0;
			assign seed[i]   = ctl.start && ctl.start_up;
		end else begin : g_lo
			assign tok_lo[i] = tok_vec[i-1];
			if (i == SLOTS - 1) begin : g_seed_top
				assign seed[i] = ctl.start && !ctl.start_up;
			end else begin : g_seed_mid
				assign seed[i] = 1'b0;
			end
		end
		if (i == SLOTS - 1) begin : g_hi_end
			assign tok_hi[i] = 1'b0;
		end else begin : g_hi
			assign tok_hi[i] = tok_vec[i+1];
		end

		dtp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.seed   (seed[i]),
			.tok_lo (tok_lo[i]),
			.tok_hi (tok_hi[i]),
			.tok    (tok_vec[i]),
			.rsp    (rsp[i])
		);
	end

	always_comb begin
		hit       = 1'b0;
		hit_owner = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hit       = hit | rsp[i].hit;
			hit_owner = hit_owner | rsp[i].owner;
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan token in the chain");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_stall |-> tok_vec == '0)
		else $error("scan token left in the chain while idle");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.kind == KIND_FIRED)
		else $error("non-final result item that is not a fired timer");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the deadline timer pool with directed and random items.
`default_nettype none

module testbench;
	import dtp_pkg::*;

	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int HOLD_AT       = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int RANDOM_ITEMS  = 16;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	cmd_item_t cmd = '0;
	logic      cmd_stall;
	logic      res_valid;
	res_item_t res;
	logic      res_stall = 1'b0;

	// pool model state
	logic                  tmr_live  [SLOTS];
	logic [31:0]           tmr_due   [SLOTS];
	logic [OWNER_BITS-1:0] tmr_owner [SLOTS];
	logic                  tmr_halted;

	cmd_item_t pending_cmds [$];
	res_item_t owed_results [$];
	res_item_t want;

	int errors = 0;
	int res_seen = 0;
	int rx_wait = 0;
	int tx_wait = 0;
	bit rx_calm = 1'b0;
	bit tx_calm = 1'b0;
	int idle_cycles;

	deadline_timer_pool i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_item_t result_of(kind_t k, int s, logic [15:0] o, int n, logic l);
		res_item_t r;
		r.kind            = k;
		r.slot            = 6'(s);
		r.fired_owner     = o;
		r.cancelled_count = 7'(n);
		r.last            = l;
		return r;
	endfunction

	function automatic void owe(res_item_t r);
		owed_results.insert(owed_results.size(), r);
	endfunction

	function automatic void fire_due(logic [31:0] now);
		int fired;
		res_item_t r;
		fired = 0;
		if (!tmr_halted) begin
			for (int i = SLOTS - 1; i >= 0; i--) begin
				if (tmr_live[i] && tmr_due[i] <= now) begin
					tmr_live[i] = 1'b0;
					owe(result_of(KIND_FIRED, i, 16'(tmr_owner[i]), 0, 1'b0));
					fired++;
				end
			end
		end
		if (fired == 0) begin
			owe(result_of(KIND_DONE, 0, '0, 0, 1'b1));
		end else begin
			r = owed_results.pop_back();
			r.last = 1'b1;
			owe(r);
		end
	endfunction

	function automatic void pool_apply(cmd_item_t c);
		logic [OWNER_BITS-1:0] who;
		int freed;
		int slot_free;
		who = c.owner_id[OWNER_BITS-1:0];
		freed = 0;
		slot_free = -1;
		case (c.mode)
			MODE_ARM: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!tmr_live[i])
						slot_free = i;
				if (slot_free < 0) begin
					owe(result_of(KIND_FULL, 0, '0, 0, 1'b1));
				end else begin
					tmr_live[slot_free]  = 1'b1;
					tmr_owner[slot_free] = who;
					tmr_due[slot_free]   = c.now_ms + c.delay_ms;
					owe(result_of(KIND_ARMED, slot_free, 16'(who), 0, 1'b1));
				end
			end
			MODE_CANCEL, MODE_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tmr_live[i] && (c.mode == MODE_CLEAR || tmr_owner[i] == who)) begin
						tmr_live[i] = 1'b0;
						freed++;
					end
				end
				owe(result_of(KIND_DONE, 0, '0, freed, 1'b1));
			end
			MODE_TICK: fire_due(c.now_ms);
			MODE_HALT: begin
				tmr_halted = 1'b1;
				owe(result_of(KIND_DONE, 0, '0, 0, 1'b1));
			end
			MODE_RUN: begin
				tmr_halted = 1'b0;
				fire_due(c.now_ms);
			end
			default: owe(result_of(KIND_DONE, 0, '0, 0, 1'b1));
		endcase
	endfunction

	function automatic void push_cmd(logic [2:0] m, logic [15:0] who, logic [31:0] dly,
			logic [31:0] at);
		cmd_item_t c;
		c.mode     = m;
		c.owner_id = who;
		c.delay_ms = dly;
		c.now_ms   = at;
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic logic [15:0] pick_owner();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(1, 4));
	endfunction

	function automatic void field_diff(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				pool_apply(cmd);
				if ($urandom_range(0, 15) == 0)
					tx_calm = !tx_calm;
				tx_wait = tx_calm ? 0 : $urandom_range(0, 8);
			end else if (!cmd_valid && tx_wait != 0) begin
				tx_wait--;
			end
			if (cmd_valid && cmd_stall) begin
				cmd_valid <= 1'b1;
			end else if (tx_wait == 0 && pending_cmds.size() != 0) begin
				cmd       <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected item, expected none, got %0h", $time, res);
					errors++;
				end else begin
					want = owed_results.pop_front();
					field_diff("kind", want.kind, res.kind);
					field_diff("slot", want.slot, res.slot);
					field_diff("fired_owner", want.fired_owner, res.fired_owner);
					field_diff("cancelled_count", want.cancelled_count, res.cancelled_count);
					field_diff("last", want.last, res.last);
				end
				res_seen++;
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
				if (res_seen == HOLD_AT)
					rx_wait = HOLD_CYCLES;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			res_stall <= (rx_wait != 0);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [31:0] clock_ms;
		int          rand_end;
		int          n;

		for (int i = 0; i < SLOTS; i++) begin
			tmr_live[i]  = 1'b0;
			tmr_due[i]   = '0;
			tmr_owner[i] = '0;
		end
		tmr_halted = 1'b0;

		// directed: empty table, wrap, halt, spare modes, cancel, clear
		push_cmd(MODE_TICK,   16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_CANCEL, 16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_CLEAR,  16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_ARM,    16'hFFFF, 32'd0,         32'd0);
		push_cmd(MODE_ARM,    16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(MODE_ARM,    16'h1234, 32'd100,       32'hFFFF_FFF0);
		push_cmd(MODE_ARM,    16'hFFFF, 32'hFFFF_FFFF, 32'd0);
		push_cmd(MODE_TICK,   16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_HALT,   16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_TICK,   16'h0000, 32'd0,         32'hFFFF_FFFF);
		push_cmd(MODE_SPARE6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(MODE_SPARE7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(MODE_RUN,    16'h0000, 32'd0,         32'h0000_0054);
		push_cmd(MODE_ARM,    16'hFFFF, 32'd5,         32'd10);
		push_cmd(MODE_CANCEL, 16'hFFFF, 32'd0,         32'd0);
		push_cmd(MODE_ARM,    16'h0000, 32'd0,         32'h8000_0000);
		push_cmd(MODE_RUN,    16'h0000, 32'd0,         32'hFFFF_FFFF);
		for (int i = 0; i < 3; i++)
			push_cmd(MODE_ARM, 16'h0007, 32'd1, 32'd1);
		push_cmd(MODE_CLEAR,  16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_HALT,   16'h0000, 32'd0,         32'd0);
		push_cmd(MODE_ARM,    16'h5555, 32'd0,         32'd5);
		push_cmd(MODE_RUN,    16'h0000, 32'd0,         32'hFFFF_FFFF);

		// fill the table, overflow it, then fire every slot at once
		for (int i = 0; i < SLOTS + 2; i++)
			push_cmd(MODE_ARM, 16'($urandom_range(1, 4)), 32'($urandom_range(0, 5000)), 32'd0);
		push_cmd(MODE_TICK, 16'h0000, 32'd0, 32'hFFFF_FFFF);
		for (int i = 0; i < 8; i++)
			push_cmd(MODE_ARM, 16'($urandom_range(1, 2)), 32'($urandom), 32'($urandom));
		push_cmd(MODE_CANCEL, 16'h0001, 32'd0, 32'd0);
		push_cmd(MODE_CLEAR,  16'h0000, 32'd0, 32'd0);

		// random: mostly arm/tick timelines that cross the 32-bit wrap, some noise
		clock_ms = 32'hFFFF_FF00 - 32'($urandom_range(0, 1000));
		rand_end = pending_cmds.size() + RANDOM_ITEMS;
		while (pending_cmds.size() < rand_end) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						push_cmd(MODE_ARM, pick_owner(), 32'($urandom_range(0, 200)), clock_ms);
					if ($urandom_range(0, 2) == 0)
						push_cmd(MODE_CANCEL, pick_owner(), 32'($urandom), 32'($urandom));
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++) begin
						clock_ms = clock_ms + 32'($urandom_range(0, 120));
						push_cmd(($urandom_range(0, 3) == 0) ? MODE_RUN : MODE_TICK,
							16'($urandom), 32'($urandom), clock_ms);
					end
				end
				5: begin
					push_cmd(MODE_HALT, 16'($urandom), 32'($urandom), 32'($urandom));
					push_cmd(MODE_TICK, 16'($urandom), 32'($urandom), clock_ms + 32'd500);
					push_cmd(MODE_ARM, pick_owner(), 32'($urandom_range(0, 50)), clock_ms);
					clock_ms = clock_ms + 32'($urandom_range(0, 300));
					push_cmd(MODE_RUN, 16'($urandom), 32'($urandom), clock_ms);
				end
				6: push_cmd(MODE_CANCEL, pick_owner(), 32'($urandom), 32'($urandom));
				7: push_cmd(MODE_CLEAR, 16'($urandom), 32'($urandom), 32'($urandom));
				default: push_cmd(3'($urandom_range(0, 7)), 16'($urandom), 32'($urandom),
					32'($urandom));
			endcase
		end
		push_cmd(MODE_RUN, 16'h0000, 32'd0, 32'hFFFF_FFFF);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
